// File: hdl/onewire_bus_master_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 1-Wire bus master engine
// Concurrent assertion helpers, included by the engine top to check its logic.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_BUS_MASTER_ENGINE_UNIT_ASSERT_SVH
`define ONEWIRE_BUS_MASTER_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBME_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define OBME_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("assertion failed: label");

`endif

// File: hdl/obme_pkg.sv
// ----------------------------------------------------------------------------
// 1-Wire bus master engine package
// Phase, command and status codes, register indexes, phase durations and shared types.
// ----------------------------------------------------------------------------
package obme_pkg;

    // Default width of the microsecond timer.
    localparam int TIMER_WIDTH_DEF = 11;

    // Bus phases.
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_WAIT  = 4'd2;
    localparam logic [3:0] PH_RST_HOLD  = 4'd3;
    localparam logic [3:0] PH_WR_LOW    = 4'd4;
    localparam logic [3:0] PH_WR_VAL    = 4'd5;
    localparam logic [3:0] PH_WR_GAP    = 4'd6;
    localparam logic [3:0] PH_RD_LOW    = 4'd7;
    localparam logic [3:0] PH_RD_WAIT   = 4'd8;
    localparam logic [3:0] PH_RD_HOLD   = 4'd9;
    localparam logic [3:0] PH_CV_SAMPLE = 4'd10;
    localparam logic [3:0] PH_CV_DELAY  = 4'd11;

    // Commands.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;

    // Completion status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
    localparam logic [1:0] ST_TIMEOUT     = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDX_TICKS = 1'b0;
    localparam logic CFG_IDX_POLLS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0]  TICKS_RESET = 8'd1;
    localparam logic [15:0] POLLS_RESET = 16'd37500;

    localparam logic [15:0] POLL_MAX = 16'hFFFF;

    // Engine state apart from the microsecond timer.
    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  prescale;
        logic [2:0]  bit_pos;
        logic [7:0]  shift;
        logic [15:0] polls;
        logic [1:0]  status;
        logic [7:0]  tx;
        logic        fault;
    } state_t;

    // One result item.
    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] status;
        logic       done;
        logic       busy;
        logic       release_line;
    } result_t;

    // Length in microseconds of a timed phase; zero for untimed phases.
    function automatic logic [9:0] phase_dur(input logic [3:0] ph);
        logic [9:0] dur;
        unique case (ph)
            PH_RST_LOW:  dur = 10'd500;
            PH_RST_WAIT: dur = 10'd100;
            PH_RST_HOLD: dur = 10'd500;
            PH_WR_LOW:   dur = 10'd3;
            PH_WR_VAL:   dur = 10'd57;
            PH_WR_GAP:   dur = 10'd3;
            PH_RD_LOW:   dur = 10'd2;
            PH_RD_WAIT:  dur = 10'd10;
            PH_RD_HOLD:  dur = 10'd48;
            PH_CV_DELAY: dur = 10'd20;
            default:     dur = 10'd0;
        endcase
        return dur;
    endfunction

endpackage

// File: hdl/onewire_bus_master_engine_unit.sv
// ----------------------------------------------------------------------------
// 1-Wire bus master engine
// Drives reset/presence, byte write, byte read and conversion wait on the bus.
// ----------------------------------------------------------------------------
// Each input item is one bus tick and yields exactly one result item. An item
// is taken every cycle: the tick logic runs from the state registers in one
// pass and its result is registered in a two-entry output buffer, and input
// ready only drops once both entries are full. Bus timing is counted in items,
// not clock cycles, through the ticks-per-microsecond prescaler.
module onewire_bus_master_engine_unit #(
    parameter int TIMER_WIDTH = obme_pkg::TIMER_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] line_level, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] op
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] line_release, [1] busy_res, [2] done_res,
                                   // [4:3] status, [12:5] read_byte, [15:13] zero
    // Configuration writes.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [7:0]             ticks_reg;
    logic [15:0]            polls_reg;
    obme_pkg::state_t       state_reg;
    obme_pkg::state_t       state_next;
    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [TIMER_WIDTH-1:0] timer_next;
    obme_pkg::result_t      res;
    obme_pkg::result_t      out_res;
    logic                   accept;

    assign accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= obme_pkg::TICKS_RESET;
            polls_reg <= obme_pkg::POLLS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                obme_pkg::CFG_IDX_TICKS: ticks_reg <= cfg_wdata[7:0];
                obme_pkg::CFG_IDX_POLLS: polls_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Tick logic.
    obme_step #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_step (
        .st          (state_reg),
        .tmr         (timer_reg),
        .ticks_per_us(ticks_reg),
        .poll_limit  (polls_reg),
        .op          (s_tuser),
        .data_byte   (s_tdata[7:0]),
        .line_level  (s_tdata[8]),
        .st_next     (state_next),
        .tmr_next    (timer_next),
        .res         (res)
    );

    // Engine state advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            timer_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
            timer_reg <= timer_next;
        end
    end

    // Result buffer.
    obme_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (res),
        .push_ready(s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, out_res.read_byte, out_res.status, out_res.done,
                      out_res.busy, out_res.release_line};

`include "onewire_bus_master_engine_unit_assert.svh"

    // A completing tick never reports busy.
    `OBME_ASSERT_IMPLY(a_done_not_busy, aclk, aresetn, accept && res.done, !res.busy)
    // Leaving a command always signals completion.
    `OBME_ASSERT_IMPLY(a_exit_done, aclk, aresetn,
        accept && state_reg.phase != obme_pkg::PH_IDLE
            && state_next.phase == obme_pkg::PH_IDLE, res.done)
    // The bit counter is back at zero whenever the engine is idle.
    `OBME_ASSERT_IMPLY(a_idle_bitpos, aclk, aresetn,
        state_reg.phase == obme_pkg::PH_IDLE, state_reg.bit_pos == 3'd0)
    // Input is only held off while a result is waiting.
    `OBME_ASSERT_IMPLY(a_stall_has_output, aclk, aresetn, !s_tready, m_tvalid)

endmodule

// File: hdl/obme_step.sv
// ----------------------------------------------------------------------------
// 1-Wire engine tick logic
// Next state and result item for one tick, from the current state and item.
// ----------------------------------------------------------------------------
module obme_step #(
    parameter int TIMER_WIDTH = obme_pkg::TIMER_WIDTH_DEF
) (
    input  obme_pkg::state_t        st,
    input  logic [TIMER_WIDTH-1:0]  tmr,
    input  logic [7:0]              ticks_per_us,
    input  logic [15:0]             poll_limit,
    input  logic [2:0]              op,
    input  logic [7:0]              data_byte,
    input  logic                    line_level,
    output obme_pkg::state_t        st_next,
    output logic [TIMER_WIDTH-1:0]  tmr_next,
    output obme_pkg::result_t       res
);

    logic [9:0]             dur;
    logic [8:0]             pre_inc;
    logic                   tick_us;
    logic [TIMER_WIDTH-1:0] tmr_inc;
    logic                   elapsed;
    logic                   done_flag;

    // Prescaler and microsecond timer of the current phase.
    always_comb begin
        dur     = obme_pkg::phase_dur(st.phase);
        pre_inc = {1'b0, st.prescale} + 9'd1;
        tick_us = pre_inc >= {1'b0, ticks_per_us};
        tmr_inc = tmr + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
        elapsed = tick_us && (tmr_inc >= TIMER_WIDTH'(dur));
    end

    // Phase sequencing.
    always_comb begin
        st_next   = st;
        tmr_next  = tmr;
        done_flag = 1'b0;

        // Timed phases advance the prescaler every tick and the timer once per microsecond.
        if (dur != 10'd0) begin
            st_next.prescale = tick_us ? 8'd0 : pre_inc[7:0];
            if (elapsed) begin
                tmr_next = '0;
            end else if (tick_us) begin
                tmr_next = tmr_inc;
            end
        end

        unique case (st.phase)
            obme_pkg::PH_IDLE: begin
                if (op == obme_pkg::OP_RESET) begin
                    st_next.fault = 1'b0;
                    st_next.phase = obme_pkg::PH_RST_LOW;
                end else if (op == obme_pkg::OP_WRITE) begin
                    st_next.tx      = data_byte;
                    st_next.bit_pos = 3'd0;
                    st_next.phase   = obme_pkg::PH_WR_LOW;
                end else if (op == obme_pkg::OP_READ) begin
                    st_next.shift   = 8'd0;
                    st_next.bit_pos = 3'd0;
                    st_next.phase   = obme_pkg::PH_RD_LOW;
                end else if (op == obme_pkg::OP_WAIT) begin
                    st_next.polls = 16'd0;
                    st_next.phase = obme_pkg::PH_CV_SAMPLE;
                end
            end
            obme_pkg::PH_RST_LOW: begin
                if (elapsed) st_next.phase = obme_pkg::PH_RST_WAIT;
            end
            obme_pkg::PH_RST_WAIT: begin
                if (elapsed) begin
                    st_next.fault = line_level;
                    st_next.phase = obme_pkg::PH_RST_HOLD;
                end
            end
            obme_pkg::PH_RST_HOLD: begin
                if (elapsed) begin
                    st_next.status = st.fault ? obme_pkg::ST_NO_PRESENCE : obme_pkg::ST_OK;
                    done_flag      = 1'b1;
                    st_next.phase  = obme_pkg::PH_IDLE;
                end
            end
            obme_pkg::PH_WR_LOW: begin
                if (elapsed) st_next.phase = obme_pkg::PH_WR_VAL;
            end
            obme_pkg::PH_WR_VAL: begin
                if (elapsed) st_next.phase = obme_pkg::PH_WR_GAP;
            end
            obme_pkg::PH_WR_GAP: begin
                if (elapsed) begin
                    if (st.bit_pos == 3'd7) begin
                        st_next.bit_pos = 3'd0;
                        st_next.status  = obme_pkg::ST_OK;
                        done_flag       = 1'b1;
                        st_next.phase   = obme_pkg::PH_IDLE;
                    end else begin
                        st_next.bit_pos = st.bit_pos + 3'd1;
                        st_next.phase   = obme_pkg::PH_WR_LOW;
                    end
                end
            end
            obme_pkg::PH_RD_LOW: begin
                if (elapsed) st_next.phase = obme_pkg::PH_RD_WAIT;
            end
            obme_pkg::PH_RD_WAIT: begin
                if (elapsed) begin
                    if (line_level) st_next.shift[st.bit_pos] = 1'b1;
                    st_next.phase = obme_pkg::PH_RD_HOLD;
                end
            end
            obme_pkg::PH_RD_HOLD: begin
                if (elapsed) begin
                    if (st.bit_pos == 3'd7) begin
                        st_next.bit_pos = 3'd0;
                        st_next.status  = obme_pkg::ST_OK;
                        done_flag       = 1'b1;
                        st_next.phase   = obme_pkg::PH_IDLE;
                    end else begin
                        st_next.bit_pos = st.bit_pos + 3'd1;
                        st_next.phase   = obme_pkg::PH_RD_LOW;
                    end
                end
            end
            obme_pkg::PH_CV_SAMPLE: begin
                if (line_level) begin
                    st_next.status = obme_pkg::ST_OK;
                    done_flag      = 1'b1;
                    st_next.phase  = obme_pkg::PH_IDLE;
                end else begin
                    if (st.polls != obme_pkg::POLL_MAX) st_next.polls = st.polls + 16'd1;
                    st_next.phase = obme_pkg::PH_CV_DELAY;
                end
            end
            obme_pkg::PH_CV_DELAY: begin
                if (elapsed) begin
                    if (st.polls >= poll_limit) begin
                        st_next.status = obme_pkg::ST_TIMEOUT;
                        done_flag      = 1'b1;
                        st_next.phase  = obme_pkg::PH_IDLE;
                    end else begin
                        st_next.phase = obme_pkg::PH_CV_SAMPLE;
                    end
                end
            end
            default: begin
                st_next.phase = obme_pkg::PH_IDLE;
            end
        endcase

        // Any phase change restarts the phase timing.
        if (st_next.phase != st.phase) begin
            st_next.prescale = 8'd0;
            tmr_next         = '0;
        end
    end

    // Result item, taken from the updated state.
    always_comb begin
        if (st_next.phase == obme_pkg::PH_RST_LOW || st_next.phase == obme_pkg::PH_WR_LOW
                || st_next.phase == obme_pkg::PH_RD_LOW) begin
            res.release_line = 1'b0;
        end else if (st_next.phase == obme_pkg::PH_WR_VAL) begin
            res.release_line = st_next.tx[st_next.bit_pos];
        end else begin
            res.release_line = 1'b1;
        end
        res.busy      = st_next.phase != obme_pkg::PH_IDLE;
        res.done      = done_flag;
        res.status    = st_next.status;
        res.read_byte = st_next.shift;
    end

endmodule

// File: hdl/obme_skid.sv
// ----------------------------------------------------------------------------
// 1-Wire engine result buffer
// Two-entry output register with a skid stage so input ready is registered.
// ----------------------------------------------------------------------------
module obme_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  obme_pkg::result_t push_data,
    output logic              push_ready,
    output logic              out_valid,
    output obme_pkg::result_t out_data,
    input  logic              out_ready
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    obme_pkg::result_t main_reg;
    obme_pkg::result_t skid_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload; the skid entry drains first, and no item is pushed while it is full.
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

// File: tb/tb_onewire_bus_master_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 1-Wire bus master engine
// Streams bus ticks into the engine, predicts every result item with its own
// tick-level model of the engine and compares the results field by field. It
// runs unused op codes, a byte read with stray commands and conversion waits
// under several timing settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_onewire_bus_master_engine_unit;

    localparam int IDLE_PCT    = 36;
    localparam int STALL_LIMIT = 5000;
    localparam int CALM_FROM   = 200;
    localparam int CALM_TO     = 450;
    localparam int ITEM_BUDGET = 600;
    // Stray commands stop well before a noisy command ends.
    localparam int NOISE_TICKS = 400;

    // Op codes that the engine treats as no command.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // One bus tick as it is sent to the engine.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       line;
    } tick_t;

    // How the sampled line behaves during a command.
    typedef enum logic [1:0] {LN_RANDOM, LN_LOW, LN_HIGH, LN_RISE} line_mode_e;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = obme_pkg::OP_NONE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = obme_pkg::CFG_IDX_TICKS;
    logic [15:0] cfg_wdata = '0;

    tick_t               tick_queue[$];
    obme_pkg::result_t   due_outputs[$];

    // Engine copy used for prediction.
    logic [7:0]                           cfg_ticks   = obme_pkg::TICKS_RESET;
    logic [15:0]                          cfg_polls   = obme_pkg::POLLS_RESET;
    logic [3:0]                           eng_phase   = obme_pkg::PH_IDLE;
    logic [obme_pkg::TIMER_WIDTH_DEF-1:0] us_timer    = '0;
    logic [7:0]                           prescale    = '0;
    logic [2:0]                           bit_pos     = '0;
    logic [7:0]                           shift_byte  = '0;
    logic [15:0]                          poll_cnt    = '0;
    logic [1:0]                           held_status = obme_pkg::ST_OK;
    logic [7:0]                           tx_byte     = '0;
    logic                                 fault       = 1'b0;

    int unsigned mismatches   = 0;
    int unsigned cyc          = 0;
    int unsigned stall_cycles = 0;
    int unsigned items_sent   = 0;
    logic        tail_noise   = 1'b0;
    logic        calm;

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    onewire_bus_master_engine_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Start a new phase with the timer and prescaler cleared.
    function automatic void enter_phase(input logic [3:0] ph);
        eng_phase = ph;
        us_timer  = '0;
        prescale  = '0;
    endfunction

    // Count one tick; true when dur microseconds of the phase have passed.
    function automatic logic us_elapsed(input int unsigned dur);
        int unsigned nxt;
        nxt = prescale + 1;
        if (nxt < cfg_ticks) begin
            prescale = 8'(nxt);
            return 1'b0;
        end
        prescale = '0;
        us_timer = us_timer + 1'b1;
        if (us_timer >= dur) begin
            us_timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the engine copy by one tick and return the outputs it shows.
    function automatic obme_pkg::result_t next_bus_outputs(input logic [2:0] op,
                                                           input logic [7:0] data,
                                                           input logic line);
        obme_pkg::result_t r;
        logic              done;
        done = 1'b0;
        case (eng_phase)
            obme_pkg::PH_IDLE: begin
                if (op == obme_pkg::OP_RESET) begin
                    fault = 1'b0;
                    enter_phase(obme_pkg::PH_RST_LOW);
                end else if (op == obme_pkg::OP_WRITE) begin
                    tx_byte = data;
                    bit_pos = '0;
                    enter_phase(obme_pkg::PH_WR_LOW);
                end else if (op == obme_pkg::OP_READ) begin
                    shift_byte = '0;
                    bit_pos    = '0;
                    enter_phase(obme_pkg::PH_RD_LOW);
                end else if (op == obme_pkg::OP_WAIT) begin
                    poll_cnt = '0;
                    enter_phase(obme_pkg::PH_CV_SAMPLE);
                end
            end
            obme_pkg::PH_RST_LOW: if (us_elapsed(500)) enter_phase(obme_pkg::PH_RST_WAIT);
            obme_pkg::PH_RST_WAIT: begin
                // The presence pulse is sampled once, at the end of the wait.
                if (us_elapsed(100)) begin
                    fault = line;
                    enter_phase(obme_pkg::PH_RST_HOLD);
                end
            end
            obme_pkg::PH_RST_HOLD: begin
                if (us_elapsed(500)) begin
                    held_status = fault ? obme_pkg::ST_NO_PRESENCE : obme_pkg::ST_OK;
                    done        = 1'b1;
                    enter_phase(obme_pkg::PH_IDLE);
                end
            end
            obme_pkg::PH_WR_LOW:  if (us_elapsed(3)) enter_phase(obme_pkg::PH_WR_VAL);
            obme_pkg::PH_WR_VAL:  if (us_elapsed(57)) enter_phase(obme_pkg::PH_WR_GAP);
            obme_pkg::PH_RD_LOW:  if (us_elapsed(2)) enter_phase(obme_pkg::PH_RD_WAIT);
            obme_pkg::PH_RD_WAIT: begin
                if (us_elapsed(10)) begin
                    if (line) shift_byte[bit_pos] = 1'b1;
                    enter_phase(obme_pkg::PH_RD_HOLD);
                end
            end
            // Last slot of a bit: finish the byte or start the next bit.
            obme_pkg::PH_WR_GAP, obme_pkg::PH_RD_HOLD: begin
                if (us_elapsed((eng_phase == obme_pkg::PH_WR_GAP) ? 3 : 48)) begin
                    if (bit_pos == 3'd7) begin
                        bit_pos     = '0;
                        held_status = obme_pkg::ST_OK;
                        done        = 1'b1;
                        enter_phase(obme_pkg::PH_IDLE);
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                        enter_phase((eng_phase == obme_pkg::PH_WR_GAP) ?
                                    obme_pkg::PH_WR_LOW : obme_pkg::PH_RD_LOW);
                    end
                end
            end
            obme_pkg::PH_CV_SAMPLE: begin
                if (line) begin
                    held_status = obme_pkg::ST_OK;
                    done        = 1'b1;
                    enter_phase(obme_pkg::PH_IDLE);
                end else begin
                    if (poll_cnt != obme_pkg::POLL_MAX) poll_cnt = poll_cnt + 1'b1;
                    enter_phase(obme_pkg::PH_CV_DELAY);
                end
            end
            obme_pkg::PH_CV_DELAY: begin
                if (us_elapsed(20)) begin
                    if (poll_cnt >= cfg_polls) begin
                        held_status = obme_pkg::ST_TIMEOUT;
                        done        = 1'b1;
                        enter_phase(obme_pkg::PH_IDLE);
                    end else begin
                        enter_phase(obme_pkg::PH_CV_SAMPLE);
                    end
                end
            end
            default: enter_phase(obme_pkg::PH_IDLE);
        endcase
        if (eng_phase == obme_pkg::PH_RST_LOW || eng_phase == obme_pkg::PH_WR_LOW
                || eng_phase == obme_pkg::PH_RD_LOW)
            r.release_line = 1'b0;
        else if (eng_phase == obme_pkg::PH_WR_VAL)
            r.release_line = tx_byte[bit_pos];
        else
            r.release_line = 1'b1;
        r.busy      = (eng_phase != obme_pkg::PH_IDLE);
        r.done      = done;
        r.status    = held_status;
        r.read_byte = shift_byte;
        return r;
    endfunction

    // Input driver: predicts each accepted item and presents the next queued one.
    always @(posedge aclk) begin
        tick_t nxt;
        if (s_tvalid && s_tready)
            due_outputs.push_back(next_bus_outputs(s_tuser, s_tdata[7:0], s_tdata[8]));
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tick_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = tick_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= {7'd0, nxt.line, nxt.data};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor: each accepted item against the oldest prediction.
    always @(posedge aclk) begin
        obme_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: tdata %h", m_tdata);
            end else begin
                want = due_outputs.pop_front();
                if (m_tdata[0] !== want.release_line || m_tdata[1] !== want.busy ||
                    m_tdata[2] !== want.done || m_tdata[4:3] !== want.status ||
                    m_tdata[12:5] !== want.read_byte) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected rel %b busy %b done %b",
                                 want.release_line, want.busy, want.done,
                                 " st %0d byte %h,", want.status, want.read_byte,
                                 " got rel %b busy %b done %b", m_tdata[0], m_tdata[1],
                                 m_tdata[2], " st %0d byte %h", m_tdata[4:3],
                                 m_tdata[12:5]);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_onewire_bus_master_engine_unit NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_tick(input logic [2:0] op, input logic [7:0] data, input logic line);
        tick_t t;
        t.op   = op;
        t.data = data;
        t.line = line;
        tick_queue.push_back(t);
        items_sent++;
    endtask

    // Send a command and keep ticking until the engine is idle again.
    task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                               input line_mode_e mode, input int unsigned rise_at);
        int unsigned k;
        logic        line;
        logic [2:0]  tick_op;
        logic        seen_busy;
        k         = 0;
        seen_busy = 1'b0;
        forever begin
            @(negedge aclk);
            if (eng_phase != obme_pkg::PH_IDLE) seen_busy = 1'b1;
            if ((seen_busy && eng_phase == obme_pkg::PH_IDLE) || items_sent >= ITEM_BUDGET)
                break;
            if (tick_queue.size() <= 2) begin
                case (mode)
                    LN_RANDOM: line = 1'($urandom_range(0, 1));
                    LN_LOW:    line = 1'b0;
                    LN_HIGH:   line = 1'b1;
                    default:   line = (k >= rise_at);
                endcase
                // Commands sent while busy must be ignored by the engine.
                if (k == 0)
                    tick_op = op;
                else if (tail_noise && k < NOISE_TICKS && $urandom_range(0, 9) == 0)
                    tick_op = 3'($urandom_range(0, 7));
                else
                    tick_op = obme_pkg::OP_NONE;
                push_tick(tick_op, (k == 0) ? data : 8'($urandom), line);
                k++;
            end
        end
    endtask

    // Wait until every item has been accepted and every result checked.
    task automatic settle();
        while (tick_queue.size() != 0 || s_tvalid || due_outputs.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Register write while the engine is idle.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        settle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == obme_pkg::CFG_IDX_TICKS)
            cfg_ticks = val[7:0];
        else
            cfg_polls = val;
        @(negedge aclk);
    endtask

    // Stimulus.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Idle and unused ops first, with the reset configuration.
        push_tick(obme_pkg::OP_NONE, 8'hFF, 1'b1);
        push_tick(OP_SPARE_5, 8'h00, 1'b0);
        push_tick(OP_SPARE_6, 8'hFF, 1'b1);
        push_tick(OP_SPARE_7, 8'h5A, 1'b0);

        // A full byte read with stray commands while it is busy.
        tail_noise = 1'b1;
        run_command(obme_pkg::OP_READ, 8'h3C, LN_RANDOM, 0);
        tail_noise = 1'b0;

        // Conversion wait: one low poll, then the line rises.
        run_command(obme_pkg::OP_WAIT, 8'h00, LN_RISE, 10);

        // A zero tick rate and a zero poll limit both act as one.
        write_reg(obme_pkg::CFG_IDX_TICKS, 16'hFF00);
        write_reg(obme_pkg::CFG_IDX_POLLS, 16'h0000);
        run_command(obme_pkg::OP_WAIT, 8'h00, LN_LOW, 0);

        // Two ticks per microsecond, timing out after one poll.
        write_reg(obme_pkg::CFG_IDX_TICKS, 16'd2);
        write_reg(obme_pkg::CFG_IDX_POLLS, 16'd1);
        run_command(obme_pkg::OP_WAIT, 8'h00, LN_LOW, 0);

        settle();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && due_outputs.size() == 0) begin
            $display("tb_onewire_bus_master_engine_unit OK");
        end else begin
            $display("tb_onewire_bus_master_engine_unit NOT OK");
        end
        $finish;
    end

endmodule
